// ===== hw/rtl/drp_pkg.sv =====
// Package for the delimited record parser: payload types, byte class codes,
// character constants and default parameter values.
// No dependencies.
package drp_pkg;

    localparam int NAME_LEN_DEF    = 32;
    localparam int KEY_BITS_DEF    = 32;
    localparam int DATA_BITS_DEF   = 32;
    localparam int QUEUE_DEPTH     = 4;
    localparam int COUNT_BITS      = 6;

    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [2:0] {
        CLS_DIGIT,
        CLS_MINUS,
        CLS_SEMI,
        CLS_NL,
        CLS_BSLASH,
        CLS_OTHER,
        CLS_END
    } t_cls;

    typedef enum logic [1:0] {
        KIND_NAME   = 2'd0,
        KIND_RECORD = 2'd1,
        KIND_END    = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        STG_KEY,
        STG_DATA,
        STG_NAME,
        STG_SKIP
    } t_stage;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_mark;
    } t_in_item;

    typedef struct packed {
        t_kind              kind;
        logic [7:0]         name_byte;
        logic [4:0]         name_pos;
        logic [5:0]         name_length;
        logic signed [31:0] key_value;
        logic signed [31:0] data_value;
        logic               partial_dropped;
    } t_out_item;

    typedef struct packed {
        t_cls       cls;
        logic [7:0] text;
    } t_q_entry;

    function automatic t_cls classify(input t_in_item item);
        t_cls c;
        if (item.end_mark) begin
            c = CLS_END;
        end else if (item.text_byte >= CH_ZERO && item.text_byte <= CH_NINE) begin
            c = CLS_DIGIT;
        end else if (item.text_byte == CH_MINUS) begin
            c = CLS_MINUS;
        end else if (item.text_byte == CH_SEMI) begin
            c = CLS_SEMI;
        end else if (item.text_byte == CH_NL) begin
            c = CLS_NL;
        end else if (item.text_byte == CH_BSLASH) begin
            c = CLS_BSLASH;
        end else begin
            c = CLS_OTHER;
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/drp_if.sv =====
// Stream interfaces of the delimited record parser: input bytes and results.
// Depends on drp_pkg.
interface drp_in_if import drp_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface drp_out_if import drp_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ===== hw/rtl/delimited_record_parser.sv =====
// Top level of the delimited record parser: front classifier, queue and back
// parser. Depends on drp_pkg, drp_if, drp_front, drp_queue and drp_back.
//
// The parser takes one text byte or end mark per cycle as long as the queue has room,
// since every byte is handled by one update of the parser state in the back stage.
// A result passes the front register, a queue entry and the output register before
// it is offered. The queue of four entries lets the input side keep streaming
// while the output side stalls; once it fills, input ready drops. No clearing
// pass follows reset.
module delimited_record_parser import drp_pkg::*; #(
    parameter int NAME_LEN  = NAME_LEN_DEF,
    parameter int KEY_BITS  = KEY_BITS_DEF,
    parameter int DATA_BITS = DATA_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    drp_in_if.sink    i_in,
    drp_out_if.source o_out
);

    logic     push_valid;
    logic     push_ready;
    t_q_entry push_entry;
    logic     pop_valid;
    logic     pop_ready;
    t_q_entry pop_entry;

    drp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_entry (push_entry)
    );

    drp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_entry (push_entry),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_entry  (pop_entry)
    );

    drp_back #(
        .NAME_LEN  (NAME_LEN),
        .KEY_BITS  (KEY_BITS),
        .DATA_BITS (DATA_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_entry (pop_entry),
        .o_out       (o_out)
    );

endmodule

// ===== hw/rtl/drp_front.sv =====
// Front stage: accepts input transfers, classifies each byte and holds the
// classified entry until the queue takes it. Depends on drp_pkg and drp_if.
module drp_front import drp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    drp_in_if.sink   i_in,
    output logic     o_push_valid,
    input  logic     i_push_ready,
    output t_q_entry o_push_entry
);

    logic     r_valid;
    logic     n_valid;
    t_q_entry r_entry;
    t_q_entry n_entry;

    assign i_in.ready   = !r_valid || i_push_ready;
    assign o_push_valid = r_valid;
    assign o_push_entry = r_entry;

    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        if (i_push_ready) begin
            n_valid = 1'b0;
        end
        if (i_in.valid && i_in.ready) begin
            n_valid      = 1'b1;
            n_entry.cls  = classify(i_in.data);
            n_entry.text = i_in.data.text_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_entry <= n_entry;
    end

endmodule

// ===== hw/rtl/drp_queue.sv =====
// Short queue of classified entries between the front and back stages.
// Depends on drp_pkg.
module drp_queue import drp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push_valid,
    output logic     o_push_ready,
    input  t_q_entry i_push_entry,
    output logic     o_pop_valid,
    input  logic     i_pop_ready,
    output t_q_entry o_pop_entry
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    t_q_entry            r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [PTR_BITS:0]   r_count;
    logic                push;
    logic                pop;

    assign o_push_ready = r_count != (PTR_BITS + 1)'(QUEUE_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_entry  = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (PTR_BITS + 1)'(push) - (PTR_BITS + 1)'(pop);
        end
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

endmodule

// ===== hw/rtl/drp_back.sv =====
// Back stage: parser state machine that accumulates key and data, emits name
// bytes and records, and holds each result in an output register.
// Depends on drp_pkg and drp_if.
module drp_back import drp_pkg::*; #(
    parameter int NAME_LEN  = NAME_LEN_DEF,
    parameter int KEY_BITS  = KEY_BITS_DEF,
    parameter int DATA_BITS = DATA_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_pop_valid,
    output logic     o_pop_ready,
    input  t_q_entry i_pop_entry,
    drp_out_if.source o_out
);

    t_stage                r_stage;
    t_stage                n_stage;
    logic                  r_negative;
    logic                  n_negative;
    logic                  r_at_start;
    logic                  n_at_start;
    logic                  r_escape;
    logic                  n_escape;
    logic [KEY_BITS-1:0]   r_key_acc;
    logic [KEY_BITS-1:0]   n_key_acc;
    logic [DATA_BITS-1:0]  r_data_acc;
    logic [DATA_BITS-1:0]  n_data_acc;
    logic [COUNT_BITS-1:0] r_count;
    logic [COUNT_BITS-1:0] n_count;
    logic                  r_in_record;
    logic                  n_in_record;
    logic                  r_out_valid;
    logic                  n_out_valid;
    t_out_item             r_out;
    t_out_item             n_out;

    logic                  take;

    assign o_pop_ready = !r_out_valid || o_out.ready;
    assign take        = i_pop_valid && o_pop_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_comb begin
        t_out_item          res;
        logic               emit;
        logic               finish;
        logic               clear;
        logic signed [63:0] key_wide;
        logic signed [63:0] data_wide;
        logic [COUNT_BITS-1:0] cnt_inc;

        n_stage     = r_stage;
        n_negative  = r_negative;
        n_at_start  = r_at_start;
        n_escape    = r_escape;
        n_key_acc   = r_key_acc;
        n_data_acc  = r_data_acc;
        n_count     = r_count;
        n_in_record = r_in_record;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        res         = '0;
        emit        = 1'b0;
        finish      = 1'b0;
        clear       = 1'b0;
        key_wide    = '0;
        data_wide   = '0;
        cnt_inc     = r_count + 1'b1;

        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        if (take) begin
            if (i_pop_entry.cls == CLS_END) begin
                emit                = 1'b1;
                clear               = 1'b1;
                res.kind            = KIND_END;
                res.partial_dropped = r_in_record;
            end else begin
                n_in_record = 1'b1;
                unique case (r_stage)
                    STG_KEY, STG_DATA: begin
                        n_at_start = 1'b0;
                        priority if (r_at_start && i_pop_entry.cls == CLS_MINUS) begin
                            n_negative = 1'b1;
                        end else if (i_pop_entry.cls == CLS_SEMI ||
                                     i_pop_entry.cls == CLS_NL) begin
                            if (r_stage == STG_KEY) begin
                                n_key_acc = r_negative ? '0 - r_key_acc : r_key_acc;
                            end else begin
                                n_data_acc = r_negative ? '0 - r_data_acc : r_data_acc;
                            end
                            if (i_pop_entry.cls == CLS_NL) begin
                                finish = 1'b1;
                            end else begin
                                n_negative = 1'b0;
                                n_at_start = 1'b1;
                                n_stage    = (r_stage == STG_KEY) ? STG_DATA : STG_NAME;
                            end
                        end else if (i_pop_entry.cls == CLS_DIGIT) begin
                            // Times ten as two shifted copies.
                            if (r_stage == STG_KEY) begin
                                n_key_acc = (r_key_acc << 3) + (r_key_acc << 1)
                                          + KEY_BITS'(i_pop_entry.text[3:0]);
                            end else begin
                                n_data_acc = (r_data_acc << 3) + (r_data_acc << 1)
                                           + DATA_BITS'(i_pop_entry.text[3:0]);
                            end
                        end else begin
                        end
                    end
                    STG_NAME: begin
                        priority if (!r_escape && i_pop_entry.cls == CLS_NL) begin
                            finish = 1'b1;
                        end else if (!r_escape && i_pop_entry.cls == CLS_BSLASH) begin
                            n_escape = 1'b1;
                        end else begin
                            n_escape      = 1'b0;
                            emit          = 1'b1;
                            res.kind      = KIND_NAME;
                            res.name_byte = i_pop_entry.text;
                            res.name_pos  = r_count[4:0];
                            n_count       = cnt_inc;
                            if (cnt_inc >= COUNT_BITS'(NAME_LEN)) begin
                                n_stage = STG_SKIP;
                            end
                        end
                    end
                    STG_SKIP: begin
                        if (i_pop_entry.cls == CLS_NL) begin
                            finish = 1'b1;
                        end
                    end
                endcase
            end

            key_wide  = 64'(signed'(n_key_acc));
            data_wide = 64'(signed'(n_data_acc));
            if (finish) begin
                emit            = 1'b1;
                clear           = 1'b1;
                res.kind        = KIND_RECORD;
                res.name_length = r_count;
                res.key_value   = key_wide[31:0];
                res.data_value  = data_wide[31:0];
            end

            if (clear) begin
                n_stage     = STG_KEY;
                n_negative  = 1'b0;
                n_at_start  = 1'b1;
                n_escape    = 1'b0;
                n_key_acc   = '0;
                n_data_acc  = '0;
                n_count     = '0;
                n_in_record = 1'b0;
            end
            if (emit) begin
                n_out_valid = 1'b1;
                n_out       = res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage     <= STG_KEY;
            r_negative  <= 1'b0;
            r_at_start  <= 1'b1;
            r_escape    <= 1'b0;
            r_key_acc   <= '0;
            r_data_acc  <= '0;
            r_count     <= '0;
            r_in_record <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_stage     <= n_stage;
            r_negative  <= n_negative;
            r_at_start  <= n_at_start;
            r_escape    <= n_escape;
            r_key_acc   <= n_key_acc;
            r_data_acc  <= n_data_acc;
            r_count     <= n_count;
            r_in_record <= n_in_record;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

endmodule

// ===== hw/rtl/drp_checker.sv =====
// Port-level checks of the delimited record parser and their bind to the top
// level. Depends on drp_pkg and delimited_record_parser.
module drp_checker import drp_pkg::*; #(
    parameter int NAME_LEN = NAME_LEN_DEF
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_data
);

    // A result that is not transferred stays offered unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered right after reset");

    a_name_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.kind == KIND_NAME |->
            i_out_data.name_length == '0 && i_out_data.key_value == '0 &&
            i_out_data.data_value == '0 && !i_out_data.partial_dropped)
        else $error("name byte carries record fields");

    a_record_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.kind == KIND_RECORD |->
            i_out_data.name_length <= 6'(NAME_LEN) && i_out_data.name_byte == '0 &&
            !i_out_data.partial_dropped)
        else $error("record has bad name length or stray fields");

    a_end_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.kind == KIND_END |->
            i_out_data.name_length == '0 && i_out_data.key_value == '0 &&
            i_out_data.data_value == '0 && i_out_data.name_byte == '0)
        else $error("end of input carries record fields");

endmodule

bind delimited_record_parser drp_checker #(.NAME_LEN(NAME_LEN)) u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

// ===== dv/tb_delimited_record_parser.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for delimited_record_parser: directed and random record text
// against a scoreboard that parses the same bytes. Depends on drp_pkg, drp_if and the RTL.
module tb_delimited_record_parser;
    import drp_pkg::*;

    class record_scoreboard;
        t_stage      field_stage;
        bit          minus_seen;
        bit          field_fresh;
        bit          literal_next;
        bit          record_open;
        logic [31:0] key_sum;
        logic [31:0] data_sum;
        logic [5:0]  name_len;
        t_out_item   awaited_results[$];
        int          fail_count;

        function new();
            fail_count = 0;
            clear_state();
        endfunction

        function void clear_state();
            field_stage  = STG_KEY;
            minus_seen   = 1'b0;
            field_fresh  = 1'b1;
            literal_next = 1'b0;
            record_open  = 1'b0;
            key_sum      = '0;
            data_sum     = '0;
            name_len     = '0;
        endfunction

        function void finish_record(output t_out_item res);
            res             = '0;
            res.kind        = KIND_RECORD;
            res.name_length = name_len;
            res.key_value   = key_sum;
            res.data_value  = data_sum;
            clear_state();
        endfunction

        function void take_text_item(t_in_item it);
            t_out_item   res;
            logic [7:0]  ch;
            bit          emit;
            bit          lead;
            res  = '0;
            ch   = it.text_byte;
            emit = 1'b0;
            if (it.end_mark) begin
                res.kind            = KIND_END;
                res.partial_dropped = record_open;
                clear_state();
                emit = 1'b1;
            end else begin
                record_open = 1'b1;
                case (field_stage)
                    STG_KEY, STG_DATA: begin
                        lead        = field_fresh;
                        field_fresh = 1'b0;
                        if (lead && ch == CH_MINUS) begin
                            minus_seen = 1'b1;
                        end else if (ch == CH_SEMI || ch == CH_NL) begin
                            if (field_stage == STG_KEY) begin
                                key_sum = minus_seen ? -key_sum : key_sum;
                            end else begin
                                data_sum = minus_seen ? -data_sum : data_sum;
                            end
                            if (ch == CH_NL) begin
                                finish_record(res);
                                emit = 1'b1;
                            end else begin
                                minus_seen  = 1'b0;
                                field_fresh = 1'b1;
                                field_stage = (field_stage == STG_KEY) ? STG_DATA : STG_NAME;
                            end
                        end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
                            if (field_stage == STG_KEY) begin
                                key_sum = key_sum * 32'd10 + {24'd0, ch - CH_ZERO};
                            end else begin
                                data_sum = data_sum * 32'd10 + {24'd0, ch - CH_ZERO};
                            end
                        end
                    end
                    STG_NAME: begin
                        if (!literal_next && ch == CH_NL) begin
                            finish_record(res);
                            emit = 1'b1;
                        end else if (!literal_next && ch == CH_BSLASH) begin
                            literal_next = 1'b1;
                        end else begin
                            literal_next  = 1'b0;
                            res.kind      = KIND_NAME;
                            res.name_byte = ch;
                            res.name_pos  = name_len[4:0];
                            name_len      = name_len + 6'd1;
                            if (name_len >= NAME_LEN_DEF) begin
                                field_stage = STG_SKIP;
                            end
                            emit = 1'b1;
                        end
                    end
                    default: begin
                        if (ch == CH_NL) begin
                            finish_record(res);
                            emit = 1'b1;
                        end
                    end
                endcase
            end
            if (emit) begin
                awaited_results.push_back(res);
            end
        endfunction

        task report_mismatch(string msg);
            fail_count++;
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (awaited_results.size() == 0) begin
                report_mismatch($sformatf("result of kind %0d with none awaited", got.kind));
                return;
            end
            want = awaited_results.pop_front();
            if (got.kind !== want.kind) begin
                report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
            end
            if (got.name_byte !== want.name_byte) begin
                report_mismatch($sformatf("name_byte %h, want %h", got.name_byte,
                                          want.name_byte));
            end
            if (got.name_pos !== want.name_pos) begin
                report_mismatch($sformatf("name_pos %0d, want %0d", got.name_pos,
                                          want.name_pos));
            end
            if (got.name_length !== want.name_length) begin
                report_mismatch($sformatf("name_length %0d, want %0d", got.name_length,
                                          want.name_length));
            end
            if (got.key_value !== want.key_value) begin
                report_mismatch($sformatf("key_value %0d, want %0d", got.key_value,
                                          want.key_value));
            end
            if (got.data_value !== want.data_value) begin
                report_mismatch($sformatf("data_value %0d, want %0d", got.data_value,
                                          want.data_value));
            end
            if (got.partial_dropped !== want.partial_dropped) begin
                report_mismatch($sformatf("partial_dropped %b, want %b", got.partial_dropped,
                                          want.partial_dropped));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    drp_in_if  text_if();
    drp_out_if result_if();

    delimited_record_parser i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (text_if),
        .o_out   (result_if)
    );

    record_scoreboard board = new();
    t_in_item         text_stream[$];
    bit               idle_on;
    bit               hold_request;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = ~i_clk;
    end

    function automatic void push_text(logic [7:0] b);
        t_in_item it;
        it.text_byte = b;
        it.end_mark  = 1'b0;
        text_stream.push_back(it);
    endfunction

    function automatic void push_end();
        t_in_item it;
        it.text_byte = 8'($urandom_range(0, 255));
        it.end_mark  = 1'b1;
        text_stream.push_back(it);
    endfunction

    function automatic void push_string(string s);
        for (int k = 0; k < s.len(); k++) begin
            push_text(s[k]);
        end
    endfunction

    function automatic logic [7:0] junk_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_SEMI || b == CH_NL);
        return b;
    endfunction

    function automatic logic [7:0] plain_name_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (b == CH_NL || b == CH_BSLASH);
        return b;
    endfunction

    function automatic void add_number();
        int digits;
        if ($urandom_range(0, 3) == 0) begin
            push_text(CH_MINUS);
        end
        digits = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 13) : $urandom_range(0, 4);
        for (int k = 0; k < digits; k++) begin
            if ($urandom_range(0, 7) == 0) begin
                push_text(junk_byte());
            end
            push_text(CH_ZERO + 8'($urandom_range(0, 9)));
        end
    endfunction

    function automatic void add_record();
        int name_bytes;
        add_number();
        push_text(CH_SEMI);
        add_number();
        push_text(CH_SEMI);
        name_bytes = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 6);
        for (int k = 0; k < name_bytes; k++) begin
            if ($urandom_range(0, 7) == 0) begin
                push_text(CH_BSLASH);
                push_text(8'($urandom_range(0, 255)));
            end else begin
                push_text(plain_name_byte());
            end
        end
        if (name_bytes >= NAME_LEN_DEF && $urandom_range(0, 1) == 1) begin
            push_text(CH_BSLASH);
        end
        push_text(CH_NL);
    endfunction

    function automatic void add_random_chunk();
        int pick;
        int count;
        pick = $urandom_range(0, 19);
        if (pick < 15) begin
            add_record();
        end else if (pick < 17) begin
            add_number();
            if (pick == 16) begin
                push_text(CH_SEMI);
                add_number();
            end
            push_text(CH_NL);
        end else if (pick == 17) begin
            add_number();
            push_text(CH_SEMI);
            count = $urandom_range(0, 4);
            for (int k = 0; k < count; k++) begin
                push_text(plain_name_byte());
            end
            push_end();
        end else if (pick == 18) begin
            push_end();
        end else begin
            count = $urandom_range(1, 6);
            for (int k = 0; k < count; k++) begin
                push_text(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 1) == 1) begin
                push_end();
            end
        end
    endfunction

    task automatic send_text_item(t_in_item it);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            text_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        text_if.valid <= 1'b1;
        text_if.data  <= it;
        @(posedge i_clk);
        while (!text_if.ready) begin
            @(posedge i_clk);
        end
        board.take_text_item(it);
    endtask

    initial begin
        int stall_left;
        stall_left = 0;
        result_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                result_if.ready <= 1'b0;
            end else begin
                if (result_if.valid && result_if.ready) begin
                    board.check_result(result_if.data);
                end
                if (hold_request) begin
                    hold_request = 1'b0;
                    stall_left   = 80;
                end
                if (stall_left > 0) begin
                    stall_left--;
                    result_if.ready <= 1'b0;
                end else if (idle_on && $urandom_range(0, 5) == 0) begin
                    stall_left = $urandom_range(0, 2);
                    result_if.ready <= 1'b0;
                end else begin
                    result_if.ready <= 1'b1;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("delimited_record_parser verification failed");
        $finish;
    end

    initial begin
        int directed_count;
        int tail_start;
        text_if.valid <= 1'b0;
        text_if.data  <= '0;
        i_rst_n       <= 1'b0;
        idle_on       = 1'b1;
        hold_request  = 1'b0;

        // Directed part: clean end mark, minus handling, newline in key and data fields,
        // backslashes in numeric fields, escaped newline in the name, byte extremes and
        // an end mark that drops a partial record.
        push_end();
        push_string("-5;-\n");
        push_string("7\n");
        push_string("9-\\;\\8;\\\n");
        push_text(8'hFF);
        push_text(8'h00);
        push_text(CH_NL);
        push_string("x");
        push_end();
        directed_count = text_stream.size();

        while (text_stream.size() < 850) begin
            add_random_chunk();
        end
        tail_start = text_stream.size() - text_stream.size() / 7;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < text_stream.size(); n++) begin
            if (n == directed_count) begin
                hold_request = 1'b1;
            end
            if (n == tail_start) begin
                idle_on = 1'b0;
            end
            send_text_item(text_stream[n]);
        end
        text_if.valid <= 1'b0;

        while (board.awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (12) @(posedge i_clk);

        if (board.fail_count == 0) begin
            $display("delimited_record_parser verification clean");
        end else begin
            $display("delimited_record_parser verification failed");
        end
        $finish;
    end

endmodule
